// File: hdl/atilt_pkg.sv
`default_nettype none

package atilt_pkg;

    localparam int SQRT_STAGES  = 32;
    localparam int CORDIC_STEPS = 40;
    // squares, sum, root bits, rotations, then seven stages of degree scaling
    localparam int LATENCY      = 2 + SQRT_STAGES + CORDIC_STEPS + 7;

    localparam int XY_W = 36;
    localparam int Z_W  = 51;

    localparam logic [30:0] DEG_MUL   = 31'd1466771968;  // 256 * 5729578
    localparam logic [31:0] DEG_HALF  = 32'd50000;
    localparam logic [31:0] DEG_RECIP = 32'd2814749767;  // floor(2^48 / 100000)
    localparam logic [16:0] DEG_DIV   = 17'd100000;
    localparam logic [15:0] ANGLE_MAX = 16'd23040;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] tilt_alpha;
        logic signed [15:0] tilt_beta;
    } t_out;

    typedef struct packed {
        logic neg;
        logic zden;
        logic znum;
    } t_flags;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
        logic [16:0] mag;
        t_flags      flg;
    } t_sq_st;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        t_flags                 flg;
    } t_cord_st;

    typedef logic signed [Z_W-1:0] t_ang_tbl [0:CORDIC_STEPS-1];

    // atan(1/5) or atan(1/239) in Q62
    function automatic logic [63:0] atan_inv(input logic sel239);
        logic [63:0] p;
        logic [63:0] acc;
        int k;
        p   = sel239 ? (64'd1 << 62) / 239 : (64'd1 << 62) / 5;
        acc = '0;
        for (k = 0; k < 40; k++) begin
            if (p != 0) begin
                if (k[0]) begin
                    acc = acc - p / 64'(2 * k + 1);
                end else begin
                    acc = acc + p / 64'(2 * k + 1);
                end
                p = sel239 ? p / 239 / 239 : p / 5 / 5;
            end
        end
        return acc;
    endfunction

    // atan(2^-sh) in Q62, sh >= 1
    function automatic logic [63:0] atan_pow2(input int sh);
        logic [63:0] p;
        logic [63:0] acc;
        int k;
        p   = 64'd1 << (62 - sh);
        acc = '0;
        for (k = 0; k < 40; k++) begin
            if (p != 0) begin
                if (k[0]) begin
                    acc = acc - p / 64'(2 * k + 1);
                end else begin
                    acc = acc + p / 64'(2 * k + 1);
                end
                p = p >> (2 * sh);
            end
        end
        return acc;
    endfunction

    function automatic t_ang_tbl build_tbl();
        t_ang_tbl t;
        logic [63:0] v;
        int i;
        v = 64'(4 * atan_inv(1'b0)) - atan_inv(1'b1);
        t[0] = Z_W'((v + 64'd8192) >> 14);
        for (i = 1; i < CORDIC_STEPS; i++) begin
            t[i] = Z_W'((atan_pow2(i) + 64'd8192) >> 14);
        end
        return t;
    endfunction

    // atan(2^-i) in Q48 radians
    localparam t_ang_tbl STEP_ANGLE = build_tbl();

endpackage

`default_nettype wire

// File: hdl/atilt_angle.sv
`default_nettype none

module atilt_angle (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [15:0] i_num,
    input  wire logic signed [15:0] i_a,
    input  wire logic signed [15:0] i_b,
    output logic signed [15:0]      o_angle
);

    logic signed [31:0] w_sq_a;
    logic signed [31:0] w_sq_b;
    logic [30:0]        r_sq_a;
    logic [30:0]        r_sq_b;
    logic signed [15:0] r_num;

    assign w_sq_a = i_a * i_a;
    assign w_sq_b = i_b * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_a <= w_sq_a[30:0];
            r_sq_b <= w_sq_b[30:0];
            r_num  <= i_num;
        end
    end

    // square root, one result bit a stage
    atilt_pkg::t_sq_st r_sq [0:atilt_pkg::SQRT_STAGES];
    logic [31:0]       w_sum;

    assign w_sum = 32'(r_sq_a) + 32'(r_sq_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq[0].rem      <= {w_sum, 32'd0};
            r_sq[0].root     <= '0;
            r_sq[0].mag      <= r_num[15] ? 17'(-{r_num[15], r_num}) : {1'b0, r_num};
            r_sq[0].flg.neg  <= r_num[15];
            r_sq[0].flg.zden <= (w_sum == 32'd0);
            r_sq[0].flg.znum <= (r_num == 16'sd0);
        end
    end

    for (genvar j = 0; j < atilt_pkg::SQRT_STAGES; j++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        atilt_pkg::t_sq_st n_st;
        logic [63:0]       w_trial;

        assign w_trial = r_sq[j].root + BIT;

        always_comb begin
            n_st = r_sq[j];
            if (r_sq[j].rem >= w_trial) begin
                n_st.rem  = r_sq[j].rem - w_trial;
                n_st.root = (r_sq[j].root >> 1) + BIT;
            end else begin
                n_st.root = r_sq[j].root >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[j+1] <= n_st;
            end
        end
    end

    // vectoring rotations, one step a stage
    atilt_pkg::t_cord_st w_c0;
    atilt_pkg::t_cord_st r_cd [0:atilt_pkg::CORDIC_STEPS];

    always_comb begin
        w_c0.x   = {4'd0, r_sq[atilt_pkg::SQRT_STAGES].root[31:0]};
        w_c0.y   = {3'd0, r_sq[atilt_pkg::SQRT_STAGES].mag, 16'd0};
        w_c0.z   = '0;
        w_c0.flg = r_sq[atilt_pkg::SQRT_STAGES].flg;
    end

    assign r_cd[0] = w_c0;

    for (genvar i = 0; i < atilt_pkg::CORDIC_STEPS; i++) begin : g_cordic
        atilt_pkg::t_cord_st n_st;
        logic signed [atilt_pkg::XY_W-1:0] w_dx;
        logic signed [atilt_pkg::XY_W-1:0] w_dy;

        assign w_dx = r_cd[i].y >>> i;
        assign w_dy = r_cd[i].x >>> i;

        always_comb begin
            n_st = r_cd[i];
            if (!r_cd[i].y[atilt_pkg::XY_W-1]) begin
                n_st.x = r_cd[i].x + w_dx;
                n_st.y = r_cd[i].y - w_dy;
                n_st.z = r_cd[i].z + atilt_pkg::STEP_ANGLE[i];
            end else begin
                n_st.x = r_cd[i].x - w_dx;
                n_st.y = r_cd[i].y + w_dy;
                n_st.z = r_cd[i].z - atilt_pkg::STEP_ANGLE[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cd[i+1] <= n_st;
            end
        end
    end

    // radians to 1/256 degree, rounded
    atilt_pkg::t_cord_st w_cl;
    atilt_pkg::t_flags   r_flg [0:5];
    logic [32:0] r_zq;
    logic [63:0] r_p;
    logic [31:0] r_w;
    logic [63:0] r_qm;
    logic [31:0] r_w_d;
    logic [15:0] r_q0;
    logic [31:0] r_w_e;
    logic [15:0] r_q0_f;
    logic [17:0] r_rem;
    logic [31:0] w_rem;
    logic [15:0] w_q;
    logic [15:0] w_qc;
    logic [15:0] n_angle;
    logic signed [15:0] r_angle;

    assign w_cl = r_cd[atilt_pkg::CORDIC_STEPS];
    assign w_rem = r_w_e - 32'(r_q0) * 32'(atilt_pkg::DEG_DIV);
    assign w_q   = r_q0_f + 16'(r_rem >= 18'(atilt_pkg::DEG_DIV));
    assign w_qc  = (w_q > atilt_pkg::ANGLE_MAX) ? atilt_pkg::ANGLE_MAX : w_q;

    always_comb begin
        priority if (r_flg[5].zden) begin
            if (r_flg[5].znum) begin
                n_angle = '0;
            end else if (r_flg[5].neg) begin
                n_angle = -atilt_pkg::ANGLE_MAX;
            end else begin
                n_angle = atilt_pkg::ANGLE_MAX;
            end
        end else if (r_flg[5].znum) begin
            n_angle = '0;
        end else begin
            n_angle = r_flg[5].neg ? -w_qc : w_qc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zq     <= w_cl.z[atilt_pkg::Z_W-1] ? '0 : w_cl.z[48:16];
            r_flg[0] <= w_cl.flg;
            r_p      <= 64'(r_zq) * 64'(atilt_pkg::DEG_MUL);
            r_flg[1] <= r_flg[0];
            r_w      <= r_p[63:32] + atilt_pkg::DEG_HALF;
            r_flg[2] <= r_flg[1];
            r_qm     <= 64'(r_w) * 64'(atilt_pkg::DEG_RECIP);
            r_w_d    <= r_w;
            r_flg[3] <= r_flg[2];
            r_q0     <= r_qm[63:48];
            r_w_e    <= r_w_d;
            r_flg[4] <= r_flg[3];
            r_rem    <= w_rem[17:0];
            r_q0_f   <= r_q0;
            r_flg[5] <= r_flg[4];
            r_angle  <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

`default_nettype wire

// File: hdl/accel_tilt_angles.sv
// Tilt angles from one 3-axis accelerometer sample: tilt_alpha is the angle of X
// against the Y-Z plane and tilt_beta that of Y against the X-Z plane, both in
// 1/256 degree over -90..90, rounded to nearest. A zero denominator gives +/-90
// by the sign of the numerator, or 0. One sample is taken every clock cycle
// unless the pipeline is frozen; each sample runs through the squares, the
// 32-stage square root, the 40-stage rotation pipeline and the degree scaling.
// An output stall on a valid result freezes the whole pipeline and the input.
`default_nettype none

module accel_tilt_angles (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire atilt_pkg::t_in  i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output atilt_pkg::t_out      o_out_data
);

    logic                            w_en;
    logic [atilt_pkg::LATENCY-1:0]   r_vld;

    // advance unless the result at the output is held
    assign w_en = !(r_vld[atilt_pkg::LATENCY-1] && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[atilt_pkg::LATENCY-2:0], i_in_valid};
        end
    end

    atilt_angle u_alpha (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num   (i_in_data.accel_x),
        .i_a     (i_in_data.accel_y),
        .i_b     (i_in_data.accel_z),
        .o_angle (o_out_data.tilt_alpha)
    );

    atilt_angle u_beta (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num   (i_in_data.accel_y),
        .i_a     (i_in_data.accel_x),
        .i_b     (i_in_data.accel_z),
        .o_angle (o_out_data.tilt_beta)
    );

    assign o_in_stall  = !w_en;
    assign o_out_valid = r_vld[atilt_pkg::LATENCY-1];

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int PIPE_CYCLES = 81;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    atilt_pkg::t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    atilt_pkg::t_out o_out_data;

    atilt_pkg::t_in  samples_todo[$];
    atilt_pkg::t_out angles_due[$];
    longint step_tbl[40];
    int   n_errors = 0;
    int   n_sent = 0;
    bit   sent_now = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_left = 0;

    accel_tilt_angles dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // atan(1/n) in Q62 by the alternating series
    function automatic longint unsigned atan_inv_q62(longint unsigned n);
        longint unsigned p, acc, k;
        p = (64'd1 << 62) / n;
        acc = 0;
        k = 0;
        while (p != 0) begin
            if (k[0]) acc = acc - p / (2 * k + 1);
            else      acc = acc + p / (2 * k + 1);
            p = p / n / n;
            k++;
        end
        return acc;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] tilt_angle(longint num, longint a, longint b);
        longint unsigned s, mag, zq, q;
        longint x, y, z, dx, dy;
        s = a * a + b * b;
        if (s == 0) return num > 0 ? 16'sd23040 : (num < 0 ? -16'sd23040 : 16'sd0);
        if (num == 0) return 16'sd0;
        mag = num < 0 ? -num : num;
        x = root64(s << 32);
        y = mag << 16;
        z = 0;
        for (int i = 0; i < 40; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += step_tbl[i];
            end else begin
                x -= dx; y += dy; z -= step_tbl[i];
            end
        end
        if (z < 0) z = 0;
        zq = longint'(z) >> 16;
        q = (zq * 64'd1466771968 + (64'd50000 << 32)) / (64'd100000 << 32);
        if (q > 23040) q = 23040;
        return num < 0 ? -16'(q) : 16'(q);
    endfunction

    function automatic atilt_pkg::t_out tilt_pair(atilt_pkg::t_in s);
        atilt_pkg::t_out r;
        r.tilt_alpha = tilt_angle(s.accel_x, s.accel_y, s.accel_z);
        r.tilt_beta  = tilt_angle(s.accel_y, s.accel_x, s.accel_z);
        return r;
    endfunction

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d, expected %0d", what, $signed(got), $signed(want));
        n_errors++;
    endtask

    // idle pattern advances with the number of samples sent
    function automatic int idle_pct(bit rx);
        if (n_sent < 600) return rx ? 61 : 20;
        if (n_sent < 1200) return rx ? 20 : 61;
        return 0;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            angles_due.push_back(tilt_pair(i_in_data));
            n_sent++;
            sent_now = 1'b1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (angles_due.size() == 0) begin
                $display("unexpected transfer: alpha %0d beta %0d",
                         o_out_data.tilt_alpha, o_out_data.tilt_beta);
                n_errors++;
            end else begin
                atilt_pkg::t_out want;
                want = angles_due.pop_front();
                if (o_out_data.tilt_alpha !== want.tilt_alpha)
                    report("tilt_alpha", o_out_data.tilt_alpha, want.tilt_alpha);
                if (o_out_data.tilt_beta !== want.tilt_beta)
                    report("tilt_beta", o_out_data.tilt_beta, want.tilt_beta);
            end
        end
    end

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || sent_now)) begin
            sent_now = 1'b0;
            if (samples_todo.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
                i_in_data  <= samples_todo.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off to back the pipeline up
    always @(negedge i_clk) begin
        if (!hold_done && n_sent >= 200) begin
            hold_done = 1'b1;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= i_rst_n && ($urandom_range(99) < idle_pct(1'b1));
        end
    end

    function automatic atilt_pkg::t_in rand_sample();
        atilt_pkg::t_in s;
        s.accel_x = 16'($urandom);
        s.accel_y = 16'($urandom);
        s.accel_z = 16'($urandom);
        case ($urandom_range(5))
            0: begin
                s.accel_x = 16'($signed($urandom_range(32)) - 16);
                s.accel_y = 16'($signed($urandom_range(32)) - 16);
                s.accel_z = 16'($signed($urandom_range(32)) - 16);
            end
            1: begin s.accel_y = '0; s.accel_z = '0; end
            2: begin s.accel_x = '0; s.accel_z = '0; end
            3: s.accel_x = '0;
            4: s.accel_y = s.accel_x + 16'($signed($urandom_range(4)) - 2);
            default: ;
        endcase
        return s;
    endfunction

    initial begin
        logic signed [15:0] dir[$][3];
        longint unsigned v;
        v = 4 * atan_inv_q62(5) - atan_inv_q62(239);
        step_tbl[0] = longint'((v + 64'd8192) >> 14);
        for (int i = 1; i < 40; i++)
            step_tbl[i] = longint'((atan_inv_q62(64'd1 << i) + 64'd8192) >> 14);

        dir = '{'{0, 0, 0}, '{32767, 0, 0}, '{-32768, 0, 0}, '{0, 32767, 0},
                '{0, -32768, 0}, '{0, 0, 32767}, '{0, 0, -32768},
                '{-32768, -32768, -32768}, '{32767, 32767, 32767}, '{1, 0, 0},
                '{-1, 0, 0}, '{0, 0, 1}, '{1, 1, 1}, '{32767, -32768, 0},
                '{-32768, 32767, 1}, '{1, -1, 0}, '{100, 0, -5},
                '{-32768, 1, 0}, '{1, -32768, 32767}, '{0, 5, -7}};
        foreach (dir[i])
            samples_todo.push_back(atilt_pkg::t_in'({dir[i][0], dir[i][1], dir[i][2]}));
        repeat (1700) samples_todo.push_back(rand_sample());

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (samples_todo.size() == 0 && !i_in_valid && angles_due.size() == 0);
        repeat (PIPE_CYCLES + 40) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: accel_tilt_angles.f
hdl/atilt_pkg.sv
hdl/atilt_angle.sv
hdl/accel_tilt_angles.sv
verif/tb.sv
